// File: design/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, register indexes and coefficient decode for the
// polarisation frame converter.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int MAX_PRODUCTS = 4;
  localparam int SAMPLE_BITS  = 16;
  localparam int RES_BITS     = SAMPLE_BITS + 2;
  localparam int PROD_BITS    = 2;
  localparam int COUNT_BITS   = 3;
  localparam int FRAME_BITS   = 2;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 8;

  // frame codes, code 3 is not a frame
  localparam logic [FRAME_BITS-1:0] FRAME_STOKES   = 2'd0;
  localparam logic [FRAME_BITS-1:0] FRAME_LINEAR   = 2'd1;
  localparam logic [FRAME_BITS-1:0] FRAME_CIRCULAR = 2'd2;
  localparam logic [FRAME_BITS-1:0] FRAME_BAD      = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_IN_FRAME  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_FRAME = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_IN_COUNT  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_COUNT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_IN_PROD   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_PROD  = 3'd5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [RES_BITS-1:0]    res_t;

  typedef enum logic [2:0] {
    COEF_ZERO  = 3'd0,
    COEF_POS   = 3'd1,
    COEF_NEG   = 3'd2,
    COEF_POS_I = 3'd3,
    COEF_NEG_I = 3'd4
  } coef_e;

  // one row per output slot, one entry per input slot
  typedef coef_e     [MAX_PRODUCTS-1:0] coef_row_t;
  typedef coef_row_t [MAX_PRODUCTS-1:0] coef_mat_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0]             in_frame;
    logic [FRAME_BITS-1:0]             out_frame;
    logic [COUNT_BITS-1:0]             in_count;
    logic [COUNT_BITS-1:0]             out_count;
    logic [MAX_PRODUCTS*PROD_BITS-1:0] in_prod;
    logic [MAX_PRODUCTS*PROD_BITS-1:0] out_prod;
  } cfg_t;

  // decoded control for the lanes and the output stage
  typedef struct packed {
    coef_mat_t coef;
    logic      frame_error;
  } ctrl_t;

  localparam cfg_t CFG_RESET = '{
    in_frame:  FRAME_STOKES,
    out_frame: FRAME_STOKES,
    in_count:  COUNT_BITS'(MAX_PRODUCTS),
    out_count: COUNT_BITS'(MAX_PRODUCTS),
    in_prod:   8'd228,
    out_prod:  8'd228
  };

  // linear to stokes coefficient, row is stokes index, column linear index
  function automatic coef_e lin_coef(logic [PROD_BITS-1:0] ri, logic [PROD_BITS-1:0] ci);
    coef_e k;
    k = COEF_ZERO;
    case ({ri, ci})
      4'b00_00, 4'b00_11, 4'b01_00: k = COEF_POS;
      4'b01_11:                     k = COEF_NEG;
      4'b10_01, 4'b10_10:           k = COEF_POS;
      4'b11_01:                     k = COEF_NEG_I;
      4'b11_10:                     k = COEF_POS_I;
      default:                      k = COEF_ZERO;
    endcase
    return k;
  endfunction

  // circular to stokes coefficient
  function automatic coef_e circ_coef(logic [PROD_BITS-1:0] ri, logic [PROD_BITS-1:0] ci);
    coef_e k;
    k = COEF_ZERO;
    case ({ri, ci})
      4'b00_00, 4'b00_11, 4'b01_01, 4'b01_10, 4'b11_00: k = COEF_POS;
      4'b11_11:                                         k = COEF_NEG;
      4'b10_01:                                         k = COEF_NEG_I;
      4'b10_10:                                         k = COEF_POS_I;
      default:                                          k = COEF_ZERO;
    endcase
    return k;
  endfunction

  function automatic logic [COUNT_BITS-1:0] clamp_count(logic [COUNT_BITS-1:0] n);
    logic [COUNT_BITS-1:0] m;
    m = (n > COUNT_BITS'(MAX_PRODUCTS)) ? COUNT_BITS'(MAX_PRODUCTS) : n;
    return m;
  endfunction

  // full decode of the register set into a coefficient matrix
  function automatic ctrl_t decode_cfg(cfg_t cfg);
    ctrl_t                  ctl;
    logic [COUNT_BITS-1:0]  nin;
    logic [COUNT_BITS-1:0]  nout;
    logic                   err;
    logic                   pass;
    logic [PROD_BITS-1:0]   ri;
    logic [PROD_BITS-1:0]   ci;
    nin  = clamp_count(cfg.in_count);
    nout = clamp_count(cfg.out_count);
    err  = (cfg.in_frame == FRAME_BAD) || (cfg.out_frame == FRAME_BAD);
    pass = !err && (cfg.in_frame == cfg.out_frame) && (nin == nout);
    for (int c = 0; c < MAX_PRODUCTS; c++) begin
      if (COUNT_BITS'(c) < nin &&
          cfg.in_prod[PROD_BITS*c +: PROD_BITS] != cfg.out_prod[PROD_BITS*c +: PROD_BITS])
        pass = 1'b0;
    end
    if (!err && !pass &&
        !(cfg.out_frame == FRAME_STOKES || cfg.in_frame == cfg.out_frame))
      err = 1'b1;
    for (int r = 0; r < MAX_PRODUCTS; r++) begin
      for (int c = 0; c < MAX_PRODUCTS; c++) begin
        ri = cfg.out_prod[PROD_BITS*r +: PROD_BITS];
        ci = cfg.in_prod[PROD_BITS*c +: PROD_BITS];
        ctl.coef[r][c] = COEF_ZERO;
        if (!err && pass) begin
          if (r == c && COUNT_BITS'(r) < nout) ctl.coef[r][c] = COEF_POS;
        end else if (!err && COUNT_BITS'(r) < nout && COUNT_BITS'(c) < nin) begin
          if (cfg.in_frame == cfg.out_frame)
            ctl.coef[r][c] = (ri == ci) ? COEF_POS : COEF_ZERO;
          else if (cfg.in_frame == FRAME_LINEAR)
            ctl.coef[r][c] = lin_coef(ri, ci);
          else
            ctl.coef[r][c] = circ_coef(ri, ci);
        end
      end
    end
    ctl.frame_error = err;
    return ctl;
  endfunction

endpackage

// File: design/pfc_cfg.sv
// ----------------------------------------------------------------------------
// pfc_cfg
// Register file and coefficient decode; the decode is registered from the
// next register values so it is updated at the same edge as the registers.
// ----------------------------------------------------------------------------
module pfc_cfg import pfc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output ctrl_t                    ctrl_o
);

  cfg_t  cfg_d, cfg_q;
  ctrl_t ctrl_q;

  assign cfg_ready_o = 1'b1;

  // register write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_IN_FRAME:  cfg_d.in_frame  = cfg_data_i[FRAME_BITS-1:0];
        REG_OUT_FRAME: cfg_d.out_frame = cfg_data_i[FRAME_BITS-1:0];
        REG_IN_COUNT:  cfg_d.in_count  = cfg_data_i[COUNT_BITS-1:0];
        REG_OUT_COUNT: cfg_d.out_count = cfg_data_i[COUNT_BITS-1:0];
        REG_IN_PROD:   cfg_d.in_prod   = cfg_data_i;
        REG_OUT_PROD:  cfg_d.out_prod  = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= CFG_RESET;
      ctrl_q <= decode_cfg(CFG_RESET);
    end else begin
      cfg_q  <= cfg_d;
      ctrl_q <= decode_cfg(cfg_d);
    end
  end

  assign ctrl_o = ctrl_q;

endmodule

// File: design/pfc_lane.sv
// ----------------------------------------------------------------------------
// pfc_lane
// One output slot: sums the four input visibilities weighted by
// 0, +1, -1, +i or -i.
// ----------------------------------------------------------------------------
module pfc_lane import pfc_pkg::*; (
  input  sample_t   vis_re_i [MAX_PRODUCTS],
  input  sample_t   vis_im_i [MAX_PRODUCTS],
  input  coef_row_t coef_i,
  output res_t      res_re_o,
  output res_t      res_im_o
);

  // add, subtract or swap each input, sums wrap at the result width
  always_comb begin
    res_t acc_re;
    res_t acc_im;
    res_t ere;
    res_t eim;
    acc_re = '0;
    acc_im = '0;
    for (int c = 0; c < MAX_PRODUCTS; c++) begin
      ere = {{(RES_BITS-SAMPLE_BITS){vis_re_i[c][SAMPLE_BITS-1]}}, vis_re_i[c]};
      eim = {{(RES_BITS-SAMPLE_BITS){vis_im_i[c][SAMPLE_BITS-1]}}, vis_im_i[c]};
      case (coef_i[c])
        COEF_POS: begin
          acc_re = acc_re + ere;
          acc_im = acc_im + eim;
        end
        COEF_NEG: begin
          acc_re = acc_re - ere;
          acc_im = acc_im - eim;
        end
        COEF_POS_I: begin
          acc_re = acc_re - eim;
          acc_im = acc_im + ere;
        end
        COEF_NEG_I: begin
          acc_re = acc_re + eim;
          acc_im = acc_im - ere;
        end
        default: begin
          acc_re = acc_re;
          acc_im = acc_im;
        end
      endcase
    end
    res_re_o = acc_re;
    res_im_o = acc_im;
  end

endmodule

// File: design/pfc_merge.sv
// ----------------------------------------------------------------------------
// pfc_merge
// Output register: gathers the lane results and the error flag into one
// result transfer and holds it until taken.
// ----------------------------------------------------------------------------
module pfc_merge import pfc_pkg::*; (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  res_t                                res_re_i [MAX_PRODUCTS],
  input  res_t                                res_im_i [MAX_PRODUCTS],
  input  logic                                frame_error_i,
  output logic                                space_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [2*MAX_PRODUCTS*RES_BITS-1:0]  m_axis_tdata_o,
  output logic [0:0]                          m_axis_tuser_o
);

  logic                               valid_q;
  logic [2*MAX_PRODUCTS*RES_BITS-1:0] data_d, data_q;
  logic                               err_q;

  // stage can take a new result when empty or being drained
  assign space_o = !valid_q || m_axis_tready_i;

  // pack slots re then im, slot 0 lowest
  always_comb begin
    for (int r = 0; r < MAX_PRODUCTS; r++) begin
      data_d[2*r*RES_BITS +: RES_BITS]     = res_re_i[r];
      data_d[(2*r+1)*RES_BITS +: RES_BITS] = res_im_i[r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && space_o) begin
      data_q <= data_d;
      err_q  <= frame_error_i;
    end
  end

  assign m_axis_tvalid_o   = valid_q;
  assign m_axis_tdata_o    = data_q;
  assign m_axis_tuser_o[0] = err_q;

endmodule

// File: design/polarisation_frame_converter.sv
// ----------------------------------------------------------------------------
// polarisation_frame_converter
// Converts four complex visibilities per transfer from linear or circular
// polarisation frames into stokes, or within one frame.
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata: vis0_re..vis3_im, 16 b each
// m_axis    out  m_axis_tvalid/tready      tdata: res0_re..res3_im, 18 b each
//                                          tuser: frame_error
// cfg       in   cfg_valid/cfg_ready       cfg_index (3 b), cfg_data (8 b)
//
// One transfer per cycle while the output is not stalled; a result appears
// in the cycle after its input transfer, held in the single output register behind the four lanes.
// The coefficient matrix is decoded from the registers and stored at the same edge
// as a write. Reset restores all registers and empties the output stage.
// Input is stalled only while a result waits in the output register and
// the sink holds m_axis_tready low.
// ----------------------------------------------------------------------------
module polarisation_frame_converter import pfc_pkg::*; (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // vis0_re, vis0_im, vis1_re, vis1_im, vis2_re, vis2_im, vis3_re, vis3_im
  input  logic [2*MAX_PRODUCTS*SAMPLE_BITS-1:0] s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // res0_re, res0_im, res1_re, res1_im, res2_re, res2_im, res3_re, res3_im
  output logic [2*MAX_PRODUCTS*RES_BITS-1:0]  m_axis_tdata_o,
  // frame_error
  output logic [0:0]                          m_axis_tuser_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]             cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]            cfg_data_i
);

  ctrl_t   ctrl;
  sample_t vis_re [MAX_PRODUCTS];
  sample_t vis_im [MAX_PRODUCTS];
  res_t    res_re [MAX_PRODUCTS];
  res_t    res_im [MAX_PRODUCTS];
  logic    space;

  pfc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctrl_o      (ctrl)
  );

  // unpack input slots
  always_comb begin
    for (int c = 0; c < MAX_PRODUCTS; c++) begin
      vis_re[c] = s_axis_tdata_i[2*c*SAMPLE_BITS +: SAMPLE_BITS];
      vis_im[c] = s_axis_tdata_i[(2*c+1)*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

  // one lane per output slot
  for (genvar r = 0; r < MAX_PRODUCTS; r++) begin : g_lane
    pfc_lane u_lane (
      .vis_re_i (vis_re),
      .vis_im_i (vis_im),
      .coef_i   (ctrl.coef[r]),
      .res_re_o (res_re[r]),
      .res_im_o (res_im[r])
    );
  end

  pfc_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (s_axis_tvalid_i),
    .res_re_i        (res_re),
    .res_im_i        (res_im),
    .frame_error_i   (ctrl.frame_error),
    .space_o         (space),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  assign s_axis_tready_o = space;

endmodule

// File: design/pfc_checker.sv
// ----------------------------------------------------------------------------
// pfc_checker
// Port-level checks on the converter's transfers, bound to the top level.
// ----------------------------------------------------------------------------
module pfc_checker import pfc_pkg::*; (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tvalid_i,
  input logic                                  s_axis_tready_o,
  input logic                                  m_axis_tvalid_o,
  input logic                                  m_axis_tready_i,
  input logic [2*MAX_PRODUCTS*RES_BITS-1:0]    m_axis_tdata_o,
  input logic [0:0]                            m_axis_tuser_o,
  input logic                                  cfg_valid_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // every input transfer yields a result on the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("no result after input transfer");

  // an unsupported frame pair gives all-zero data
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("nonzero data with frame error");

  // input backpressure only while the output is stalled
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  // register writes only while no result is held
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> !m_axis_tvalid_o)
    else $error("register write with a result in flight");

endmodule

bind polarisation_frame_converter pfc_checker u_pfc_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the polarisation frame converter. Items go in
// through the slave stream, register settings through the config channel.
// A local model of the conversion predicts each result, and a checker
// compares every output transfer field by field against the oldest
// prediction. Directed tests go first, then random settings under three
// idling patterns, then a long sink stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import pfc_pkg::*;

  localparam int VIS_W = 2 * MAX_PRODUCTS * SAMPLE_BITS;
  localparam int RES_W = 2 * MAX_PRODUCTS * RES_BITS;

  // expected result of one conversion
  typedef struct packed {
    logic             err;
    logic [RES_W-1:0] data;
  } conv_result_t;

  // stokes rows, linear or circular columns
  localparam coef_e LIN_TO_STOKES [4][4] = '{
    '{COEF_POS,  COEF_ZERO,  COEF_ZERO,  COEF_POS},
    '{COEF_POS,  COEF_ZERO,  COEF_ZERO,  COEF_NEG},
    '{COEF_ZERO, COEF_POS,   COEF_POS,   COEF_ZERO},
    '{COEF_ZERO, COEF_NEG_I, COEF_POS_I, COEF_ZERO}
  };
  localparam coef_e CIRC_TO_STOKES [4][4] = '{
    '{COEF_POS,  COEF_ZERO,  COEF_ZERO,  COEF_POS},
    '{COEF_ZERO, COEF_POS,   COEF_POS,   COEF_ZERO},
    '{COEF_ZERO, COEF_NEG_I, COEF_POS_I, COEF_ZERO},
    '{COEF_POS,  COEF_ZERO,  COEF_ZERO,  COEF_NEG}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid_i = 1'b0;
  logic                     s_axis_tready_o;
  // vis0_re, vis0_im, vis1_re, vis1_im, vis2_re, vis2_im, vis3_re, vis3_im
  logic [VIS_W-1:0]         s_axis_tdata_i = '0;
  logic                     m_axis_tvalid_o;
  logic                     m_axis_tready_i = 1'b0;
  // res0_re, res0_im, res1_re, res1_im, res2_re, res2_im, res3_re, res3_im
  logic [RES_W-1:0]         m_axis_tdata_o;
  // frame_error
  logic [0:0]               m_axis_tuser_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;

  cfg_t         active_cfg = CFG_RESET;
  conv_result_t pending_results [$];
  int           mismatch_count = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           rx_hold_cycles = 0;

  polarisation_frame_converter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // frame conversion of one item under the given register set
  function automatic conv_result_t predict_conversion(cfg_t cfg, logic [VIS_W-1:0] vis);
    conv_result_t res;
    int           nin;
    int           nout;
    int           acc_re;
    int           acc_im;
    int           xre;
    int           xim;
    logic         err;
    logic         pass;
    logic         same;
    logic [1:0]   ri;
    logic [1:0]   ci;
    coef_e        k;
    nin  = (cfg.in_count > 3'd4) ? 4 : int'(cfg.in_count);
    nout = (cfg.out_count > 3'd4) ? 4 : int'(cfg.out_count);
    same = (cfg.in_frame == cfg.out_frame);
    err  = (cfg.in_frame == FRAME_BAD) || (cfg.out_frame == FRAME_BAD);
    pass = !err && same && (nin == nout);
    for (int c = 0; c < nin; c++)
      if (cfg.in_prod[2*c +: 2] != cfg.out_prod[2*c +: 2]) pass = 1'b0;
    // only conversions into stokes or within one frame are supported
    if (!err && !pass && !(cfg.out_frame == FRAME_STOKES || same)) err = 1'b1;
    res.err  = err;
    res.data = '0;
    if (!err) begin
      for (int r = 0; r < nout; r++) begin
        acc_re = 0;
        acc_im = 0;
        ri = cfg.out_prod[2*r +: 2];
        for (int c = 0; c < nin; c++) begin
          ci  = cfg.in_prod[2*c +: 2];
          xre = int'(sample_t'(vis[2*SAMPLE_BITS*c +: SAMPLE_BITS]));
          xim = int'(sample_t'(vis[2*SAMPLE_BITS*c+SAMPLE_BITS +: SAMPLE_BITS]));
          if (pass)
            k = (r == c) ? COEF_POS : COEF_ZERO;
          else if (same)
            k = (ri == ci) ? COEF_POS : COEF_ZERO;
          else if (cfg.in_frame == FRAME_LINEAR)
            k = LIN_TO_STOKES[ri][ci];
          else
            k = CIRC_TO_STOKES[ri][ci];
          case (k)
            COEF_POS:   begin acc_re += xre; acc_im += xim; end
            COEF_NEG:   begin acc_re -= xre; acc_im -= xim; end
            COEF_POS_I: begin acc_re -= xim; acc_im += xre; end
            COEF_NEG_I: begin acc_re += xim; acc_im -= xre; end
            default: ;
          endcase
        end
        // sums wrap at the result width
        res.data[2*RES_BITS*r +: RES_BITS]          = acc_re[RES_BITS-1:0];
        res.data[2*RES_BITS*r+RES_BITS +: RES_BITS] = acc_im[RES_BITS-1:0];
      end
    end
    return res;
  endfunction

  function automatic cfg_t make_cfg(logic [1:0] in_f, logic [1:0] out_f, logic [2:0] in_n,
                                    logic [2:0] out_n, logic [7:0] in_p, logic [7:0] out_p);
    cfg_t c;
    c.in_frame  = in_f;
    c.out_frame = out_f;
    c.in_count  = in_n;
    c.out_count = out_n;
    c.in_prod   = in_p;
    c.out_prod  = out_p;
    return c;
  endfunction

  // all eight fields set to one value
  function automatic logic [VIS_W-1:0] fill_vis(logic [SAMPLE_BITS-1:0] v);
    return {2*MAX_PRODUCTS{v}};
  endfunction

  // random item, with a share of boundary values
  function automatic logic [VIS_W-1:0] random_vis();
    logic [VIS_W-1:0]       vis;
    logic [SAMPLE_BITS-1:0] edge_vals [4];
    int                     mode;
    edge_vals = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
    mode = $urandom_range(99);
    for (int f = 0; f < 2*MAX_PRODUCTS; f++) begin
      if (mode < 70)
        vis[SAMPLE_BITS*f +: SAMPLE_BITS] = SAMPLE_BITS'($urandom);
      else
        vis[SAMPLE_BITS*f +: SAMPLE_BITS] = edge_vals[$urandom_range(3)];
    end
    if (mode >= 88) vis = fill_vis(edge_vals[$urandom_range(1)]);
    return vis;
  endfunction

  // random register set, mostly supported conversions
  function automatic cfg_t random_cfg();
    cfg_t       c;
    logic [7:0] perms [4];
    int         kind;
    perms = '{8'd228, 8'd27, 8'd141, 8'd114};
    kind  = $urandom_range(99);
    c.in_count  = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'd4;
    c.out_count = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'd4;
    c.in_prod   = ($urandom_range(2) == 0) ? 8'($urandom) : perms[$urandom_range(3)];
    c.out_prod  = ($urandom_range(2) == 0) ? 8'($urandom) : perms[$urandom_range(3)];
    if (kind < 30) begin
      c.in_frame  = FRAME_LINEAR;
      c.out_frame = FRAME_STOKES;
    end else if (kind < 60) begin
      c.in_frame  = FRAME_CIRCULAR;
      c.out_frame = FRAME_STOKES;
    end else if (kind < 75) begin
      c.in_frame  = 2'($urandom_range(2));
      c.out_frame = c.in_frame;
    end else if (kind < 90) begin
      // pass-through
      c.in_frame  = 2'($urandom_range(2));
      c.out_frame = c.in_frame;
      c.out_count = c.in_count;
      c.out_prod  = c.in_prod;
    end else begin
      c.in_frame  = 2'($urandom_range(3));
      c.out_frame = 2'($urandom_range(3));
    end
    return c;
  endfunction

  // sink ready, with long holds counted here
  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      m_axis_tready_i = 1'b0;
      rx_hold_cycles--;
    end else begin
      m_axis_tready_i = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic note_mismatch(string what, logic [RES_BITS-1:0] want, logic [RES_BITS-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %0d got %0d", what,
               $signed(want), $signed(got));
  endtask

  // compare each output transfer with the oldest prediction
  always @(posedge clk_i) begin : check_results
    conv_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch: result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        for (int r = 0; r < MAX_PRODUCTS; r++) begin
          if (m_axis_tdata_o[2*RES_BITS*r +: RES_BITS] != want.data[2*RES_BITS*r +: RES_BITS])
            note_mismatch($sformatf("res%0d_re", r),
                          want.data[2*RES_BITS*r +: RES_BITS],
                          m_axis_tdata_o[2*RES_BITS*r +: RES_BITS]);
          if (m_axis_tdata_o[2*RES_BITS*r+RES_BITS +: RES_BITS] !=
              want.data[2*RES_BITS*r+RES_BITS +: RES_BITS])
            note_mismatch($sformatf("res%0d_im", r),
                          want.data[2*RES_BITS*r+RES_BITS +: RES_BITS],
                          m_axis_tdata_o[2*RES_BITS*r+RES_BITS +: RES_BITS]);
        end
        if (m_axis_tuser_o[0] !== want.err)
          note_mismatch("frame_error", RES_BITS'(want.err), RES_BITS'(m_axis_tuser_o[0]));
      end
    end
  end

  // one input transfer; called and left at a falling edge, tvalid stays high
  task automatic send_vis(logic [VIS_W-1:0] vis);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = vis;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_results = {pending_results, predict_conversion(active_cfg, vis)};
    @(negedge clk_i);
  endtask

  // stop sending and wait for every expected result
  task automatic wait_results_drained();
    s_axis_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_IN_FRAME:  active_cfg.in_frame  = val[FRAME_BITS-1:0];
      REG_OUT_FRAME: active_cfg.out_frame = val[FRAME_BITS-1:0];
      REG_IN_COUNT:  active_cfg.in_count  = val[COUNT_BITS-1:0];
      REG_OUT_COUNT: active_cfg.out_count = val[COUNT_BITS-1:0];
      REG_IN_PROD:   active_cfg.in_prod   = val;
      REG_OUT_PROD:  active_cfg.out_prod  = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // program all registers once the block is idle
  task automatic apply_config(cfg_t c);
    wait_results_drained();
    // let the output stage and decode settle
    repeat (4) @(negedge clk_i);
    write_reg(REG_IN_FRAME,  CFG_DATA_BITS'(c.in_frame));
    write_reg(REG_OUT_FRAME, CFG_DATA_BITS'(c.out_frame));
    write_reg(REG_IN_COUNT,  CFG_DATA_BITS'(c.in_count));
    write_reg(REG_OUT_COUNT, CFG_DATA_BITS'(c.out_count));
    write_reg(REG_IN_PROD,   c.in_prod);
    write_reg(REG_OUT_PROD,  c.out_prod);
    cfg_valid_i = 1'b0;
    repeat (3) @(negedge clk_i);
  endtask

  // reset settings: stokes pass-through
  task automatic test_reset_passthrough();
    send_vis(fill_vis(16'h7fff));
    send_vis(fill_vis(16'h8000));
    send_vis(fill_vis(16'h0000));
    send_vis({4{16'haaaa, 16'h5555}});
  endtask

  task automatic test_linear_to_stokes();
    apply_config(make_cfg(FRAME_LINEAR, FRAME_STOKES, 3'd4, 3'd4, 8'd228, 8'd228));
    send_vis(fill_vis(16'h7fff));
    send_vis(fill_vis(16'h8000));
    send_vis({16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
    send_vis({4{16'h5555, 16'haaaa}});
  endtask

  task automatic test_circular_to_stokes();
    apply_config(make_cfg(FRAME_CIRCULAR, FRAME_STOKES, 3'd4, 3'd4, 8'd228, 8'd27));
    send_vis(fill_vis(16'h8000));
    send_vis({16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h8000, 16'h7fff, 16'h1234, 16'hedcb});
    send_vis(fill_vis(16'h7fff));
  endtask

  // pairs the block does not support, and frame code 3
  task automatic test_unsupported_pairs();
    apply_config(make_cfg(FRAME_STOKES, FRAME_LINEAR, 3'd4, 3'd4, 8'd228, 8'd228));
    send_vis(fill_vis(16'h7fff));
    apply_config(make_cfg(FRAME_LINEAR, FRAME_CIRCULAR, 3'd4, 3'd4, 8'd228, 8'd228));
    send_vis(fill_vis(16'h8000));
    apply_config(make_cfg(FRAME_BAD, FRAME_BAD, 3'd4, 3'd4, 8'd228, 8'd228));
    send_vis(fill_vis(16'hffff));
  endtask

  // zero counts, counts above four and partly used slots
  task automatic test_slot_counts();
    apply_config(make_cfg(FRAME_STOKES, FRAME_STOKES, 3'd0, 3'd0, 8'd228, 8'd228));
    send_vis(fill_vis(16'h7fff));
    apply_config(make_cfg(FRAME_LINEAR, FRAME_STOKES, 3'd7, 3'd5, 8'd228, 8'd228));
    send_vis(fill_vis(16'h8000));
    apply_config(make_cfg(FRAME_CIRCULAR, FRAME_STOKES, 3'd2, 3'd3, 8'd12, 8'd57));
    send_vis({4{16'h7fff, 16'h8000}});
    apply_config(make_cfg(FRAME_LINEAR, FRAME_LINEAR, 3'd3, 3'd1, 8'd228, 8'd3));
    send_vis({16'h0003, 16'h8000, 16'h0002, 16'h7fff, 16'h0001, 16'h1111, 16'h0000, 16'h2222});
  endtask

  // repeated product indices, including the wrapping sum
  task automatic test_repeated_products();
    apply_config(make_cfg(FRAME_LINEAR, FRAME_STOKES, 3'd4, 3'd4, 8'hff, 8'd228));
    send_vis(fill_vis(16'h8000));
    apply_config(make_cfg(FRAME_STOKES, FRAME_STOKES, 3'd4, 3'd3, 8'h00, 8'h00));
    send_vis(fill_vis(16'h7fff));
  endtask

  task automatic run_random_phase(int tx_pct, int rx_pct, int settings, int items);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int s = 0; s < settings; s++) begin
      apply_config(random_cfg());
      for (int n = 0; n < items; n++) send_vis(random_vis());
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(32, 76, 8, 64);
    run_random_phase(76, 32, 8, 64);
    run_random_phase(0, 0, 8, 64);
  endtask

  // long sink stall fills the output stage and stalls the input
  task automatic test_output_backpressure();
    apply_config(make_cfg(FRAME_LINEAR, FRAME_STOKES, 3'd4, 3'd4, 8'd228, 8'd228));
    tx_idle_pct    = 0;
    rx_idle_pct    = 20;
    rx_hold_cycles = 300;
    for (int n = 0; n < 48; n++) send_vis(random_vis());
    wait_results_drained();
    for (int n = 0; n < 16; n++) send_vis(random_vis());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_reset_passthrough();
    test_linear_to_stokes();
    test_circular_to_stokes();
    test_unsupported_pairs();
    test_slot_counts();
    test_repeated_products();
    test_random_traffic();
    test_output_backpressure();

    wait_results_drained();
    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
